### rtl/hfd_pkg.sv
`timescale 1ns / 1ps

package hfd_pkg;

  // CRC-8 over each data word: polynomial x^8 + x^5 + x^4 + 1, MSB first
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic [4:0] GAIN_RESET = 5'd9;

  // Scaling constants
  localparam logic [23:0] TEMP_SLOPE  = 24'd175;
  localparam logic [23:0] TEMP_OFFSET = 24'd2949075;  // 45 * 65535
  localparam logic [25:0] HUM_SCALE   = 26'd1000;
  localparam logic [16:0] FULL_SCALE  = 17'd65535;

  // Byte positions within a reply
  localparam logic [2:0] POS_T_HI  = 3'd0;
  localparam logic [2:0] POS_T_LO  = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_HI  = 3'd3;
  localparam logic [2:0] POS_H_LO  = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TEMP_CRC = 2'd1;
  localparam logic [1:0] STATUS_HUM_CRC  = 2'd2;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } byte_in_t;

  typedef struct packed {
    logic signed [12:0] temp_tenths;
    logic [9:0]         humidity_tenths;
    logic [1:0]         status;
  } result_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data);
    logic [7:0] crc;
    crc = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      if (crc[7]) begin
        crc = {crc[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[6:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

### rtl/humidity_temp_frame_decoder_top.sv
`timescale 1ns / 1ps

// Channel   | Dir | Handshake                 | Payload
// byte      | in  | byte_valid / byte_ready   | byte_data  (hfd_pkg::byte_in_t)
// result    | out | result_valid / result_ready | result   (hfd_pkg::result_t)
// gain cfg  | in  | gain_we                   | gain_wdata (5 bits, gain in tenths)
//
// One reply byte is taken per cycle while byte_ready is high; the frame tracker and CRC-8 step
// sit before the frame regs. The edge that accepts the sixth byte loads the gain product; the
// estimates by 65535 and then the corrected output register, which raises result_valid, follow.
// Synchronous reset returns the byte counter to byte 0, the CRC to 0xFF and the gain to 9.
// A stalled result holds the pipeline; byte_ready drops only when the first stage is full
// and cannot advance.

module humidity_temp_frame_decoder_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_ready,
  input  hfd_pkg::byte_in_t byte_data,
  output logic              result_valid,
  input  logic              result_ready,
  output hfd_pkg::result_t  result,
  input  logic              gain_we,
  input  logic [4:0]        gain_wdata
);

  // Configuration
  logic [4:0] gain;

  // Frame tracking state
  logic [2:0]  byte_index;
  logic [7:0]  running_crc;
  logic [7:0]  word_high;
  logic [15:0] temp_word;
  logic        temp_crc_bad;
  logic [23:0] temp_mag;   // |175*ST - 45*65535|
  logic        temp_neg;
  logic [25:0] hum_num;    // 1000*SRH

  // Pipeline stage 1: products
  logic        v1;
  logic [28:0] s1_tprod;
  logic        s1_tneg;
  logic [25:0] s1_hnum;
  logic [1:0]  s1_status;

  // Pipeline stage 2: quotient estimates and remainders
  logic        v2;
  logic [12:0] s2_tq;
  logic [16:0] s2_tr;
  logic        s2_tneg;
  logic [9:0]  s2_hq;
  logic [16:0] s2_hr;
  logic [1:0]  s2_status;

  logic adv1, adv2, adv3;
  logic byte_fire;
  logic [2:0] idx;
  logic [7:0] crc_step;
  logic [23:0] temp_scaled;
  logic [1:0] status_now;

  logic [29:0] t_sum, t_rem_w;
  logic [12:0] t_est;
  logic [26:0] h_sum, h_rem_w;
  logic [9:0]  h_est;
  logic [12:0] t_mag_q;
  logic [9:0]  h_q;

  // Stall chain: a stage moves when it is empty or the next one moves
  assign adv3 = !result_valid || result_ready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign byte_ready = adv1;
  assign byte_fire  = byte_valid && byte_ready;

  // frame_start forces byte 0
  assign idx = byte_data.frame_start ? hfd_pkg::POS_T_HI : byte_index;

  assign crc_step    = hfd_pkg::crc8_byte(running_crc, byte_data.rx_byte);
  assign temp_scaled = hfd_pkg::TEMP_SLOPE * {8'h00, temp_word};

  always_comb begin
    if (temp_crc_bad) begin
      status_now = hfd_pkg::STATUS_TEMP_CRC;
    end else if (byte_data.rx_byte != running_crc) begin
      status_now = hfd_pkg::STATUS_HUM_CRC;
    end else begin
      status_now = hfd_pkg::STATUS_OK;
    end
  end

  // Frame tracking and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      gain         <= hfd_pkg::GAIN_RESET;
      byte_index   <= hfd_pkg::POS_T_HI;
      running_crc  <= hfd_pkg::CRC_INIT;
      word_high    <= 8'h00;
      temp_word    <= 16'h0000;
      temp_crc_bad <= 1'b0;
    end else begin
      if (gain_we) begin
        gain <= gain_wdata;
      end
      if (byte_fire) begin
        unique case (idx) inside
          hfd_pkg::POS_T_HI, hfd_pkg::POS_H_HI: begin
            // Restart the CRC on the first byte of each word
            running_crc <= hfd_pkg::crc8_byte(hfd_pkg::CRC_INIT, byte_data.rx_byte);
            word_high   <= byte_data.rx_byte;
          end
          hfd_pkg::POS_T_LO: begin
            running_crc <= crc_step;
            temp_word   <= {word_high, byte_data.rx_byte};
          end
          hfd_pkg::POS_T_CRC: begin
            temp_crc_bad <= (byte_data.rx_byte != running_crc);
          end
          hfd_pkg::POS_H_LO: begin
            running_crc <= crc_step;
          end
          default: begin
          end
        endcase
        byte_index <= (idx >= hfd_pkg::POS_H_CRC) ? hfd_pkg::POS_T_HI : idx + 3'd1;
      end
    end
  end

  // Gain-independent precompute while the temperature CRC and humidity low bytes arrive
  always_ff @(posedge clk) begin
    if (byte_fire && idx == hfd_pkg::POS_T_CRC) begin
      if (temp_scaled >= hfd_pkg::TEMP_OFFSET) begin
        temp_mag <= temp_scaled - hfd_pkg::TEMP_OFFSET;
        temp_neg <= 1'b0;
      end else begin
        temp_mag <= hfd_pkg::TEMP_OFFSET - temp_scaled;
        temp_neg <= 1'b1;
      end
    end
    if (byte_fire && idx == hfd_pkg::POS_H_LO) begin
      hum_num <= hfd_pkg::HUM_SCALE * {10'h000, word_high, byte_data.rx_byte};
    end
  end

  // Stage 1: apply the gain on the sixth byte, using the gain in force now
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= byte_fire && idx == hfd_pkg::POS_H_CRC;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_tprod  <= {5'h00, temp_mag} * {24'h000000, gain};
      s1_tneg   <= temp_neg;
      s1_hnum   <= hum_num;
      s1_status <= status_now;
    end
  end

  // Divide by 65535: q ~ (x + x/65536) / 65536, never high and at most one low
  assign t_sum   = {1'b0, s1_tprod} + {17'h00000, s1_tprod[28:16]};
  assign t_est   = t_sum[28:16];
  assign t_rem_w = {1'b0, s1_tprod} - {1'b0, t_est, 16'h0000} + {17'h00000, t_est};

  assign h_sum   = {1'b0, s1_hnum} + {17'h00000, s1_hnum[25:16]};
  assign h_est   = h_sum[25:16];
  assign h_rem_w = {1'b0, s1_hnum} - {1'b0, h_est, 16'h0000} + {17'h00000, h_est};

  // Stage 2: hold the estimates and their remainders
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_tq     <= t_est;
      s2_tr     <= t_rem_w[16:0];
      s2_tneg   <= s1_tneg;
      s2_hq     <= h_est;
      s2_hr     <= h_rem_w[16:0];
      s2_status <= s1_status;
    end
  end

  // Correct the estimates when a whole divisor is left in the remainder
  assign t_mag_q = s2_tq + {12'h000, (s2_tr >= hfd_pkg::FULL_SCALE)};
  assign h_q     = s2_hq + {9'h000, (s2_hr >= hfd_pkg::FULL_SCALE)};

  // Stage 3: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv3) begin
      result_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      result.status <= s2_status;
      if (s2_status == hfd_pkg::STATUS_OK) begin
        // Truncate toward zero: negate the magnitude quotient
        result.temp_tenths     <= s2_tneg ? -$signed(t_mag_q) : $signed(t_mag_q);
        result.humidity_tenths <= h_q;
      end else begin
        // Drop the values of a reply with a CRC failure
        result.temp_tenths     <= 13'sd0;
        result.humidity_tenths <= 10'd0;
      end
    end
  end

endmodule

### rtl/hfd_checker.sv
`timescale 1ns / 1ps

module hfd_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_ready,
  input hfd_pkg::result_t result
);

  // Stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // CRC failure zeroes both values
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != hfd_pkg::STATUS_OK |->
      result.temp_tenths == 13'sd0 && result.humidity_tenths == 10'd0)
    else $error("values not cleared on CRC failure");

  // Only defined status codes and humidity in range
  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.status == hfd_pkg::STATUS_OK ||
                      result.status == hfd_pkg::STATUS_TEMP_CRC ||
                      result.status == hfd_pkg::STATUS_HUM_CRC) &&
                     result.humidity_tenths <= 10'd1000)
    else $error("result out of range");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind humidity_temp_frame_decoder_top hfd_checker u_hfd_checker (.*);

### dv/humidity_temp_frame_decoder_top_test.sv
`timescale 1ns / 1ps

module humidity_temp_frame_decoder_top_test;

  // Generous cycle budget: every byte waiting out the longest sender gap,
  // every reading waiting out the longest receiver stall, plus the long
  // hold-off and the drains between phases, taken many times over.
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int MAX_REPORTS = 10;

  // Tracks the reply framing and CRC exactly as the decoder should, and
  // keeps the readings that are still owed by the block, oldest first.
  class reply_checker;
    logic [2:0] pos;
    logic [7:0] crc;
    logic [7:0] hi_byte;
    logic [15:0] t_word;
    logic t_bad;
    logic [7:0] h_low;
    logic [4:0] gain;
    hfd_pkg::result_t expected_readings[$];
    int mismatch_count;

    function new();
      pos = hfd_pkg::POS_T_HI;
      crc = hfd_pkg::CRC_INIT;
      hi_byte = '0;
      t_word = '0;
      t_bad = 1'b0;
      h_low = '0;
      gain = hfd_pkg::GAIN_RESET;
      mismatch_count = 0;
    endfunction

    // One CRC-8 byte step, fed bit by bit from the MSB.
    static function logic [7:0] crc_next(input logic [7:0] c, input logic [7:0] d);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[7] ^ d[i];
        c = {c[6:0], 1'b0} ^ (fb ? hfd_pkg::CRC_POLY : 8'h00);
      end
      return c;
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction

    function void take_byte(input hfd_pkg::byte_in_t item);
      logic [2:0] at;
      logic [15:0] srh;
      longint num;
      longint t;
      longint h;
      hfd_pkg::result_t r;
      at = item.frame_start ? hfd_pkg::POS_T_HI : pos;
      case (at) inside
        hfd_pkg::POS_T_HI, hfd_pkg::POS_H_HI: begin
          crc = crc_next(hfd_pkg::CRC_INIT, item.rx_byte);
          hi_byte = item.rx_byte;
        end
        hfd_pkg::POS_T_LO: begin
          crc = crc_next(crc, item.rx_byte);
          t_word = {hi_byte, item.rx_byte};
        end
        hfd_pkg::POS_T_CRC: begin
          t_bad = (item.rx_byte != crc);
        end
        hfd_pkg::POS_H_LO: begin
          crc = crc_next(crc, item.rx_byte);
          h_low = item.rx_byte;
        end
        hfd_pkg::POS_H_CRC: begin
          srh = {hi_byte, h_low};
          t = 0;
          h = 0;
          if (t_bad) begin
            r.status = hfd_pkg::STATUS_TEMP_CRC;
          end else if (item.rx_byte != crc) begin
            r.status = hfd_pkg::STATUS_HUM_CRC;
          end else begin
            r.status = hfd_pkg::STATUS_OK;
          end
          if (r.status == hfd_pkg::STATUS_OK) begin
            num = (175 * longint'(t_word) - 45 * 65535) * longint'(gain);
            t = num / 65535;
            h = (1000 * longint'(srh)) / 65535;
          end
          r.temp_tenths = 13'(t);
          r.humidity_tenths = 10'(h);
          expected_readings.push_back(r);
        end
        default: ;
      endcase
      pos = (at >= hfd_pkg::POS_H_CRC) ? hfd_pkg::POS_T_HI : at + 3'd1;
    endfunction

    function void check_reading(input hfd_pkg::result_t got);
      hfd_pkg::result_t want;
      if (expected_readings.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected reading: temp %0d hum %0d status %0d",
                   got.temp_tenths, got.humidity_tenths, got.status);
        return;
      end
      want = expected_readings.pop_front();
      if (got.temp_tenths !== want.temp_tenths ||
          got.humidity_tenths !== want.humidity_tenths ||
          got.status !== want.status) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display({"reading mismatch: expected temp %0d hum %0d status %0d,",
                    " got temp %0d hum %0d status %0d"},
                   want.temp_tenths, want.humidity_tenths, want.status,
                   got.temp_tenths, got.humidity_tenths, got.status);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic byte_valid;
  logic byte_ready;
  hfd_pkg::byte_in_t byte_data;
  logic result_valid;
  logic result_ready;
  hfd_pkg::result_t result;
  logic gain_we;
  logic [4:0] gain_wdata;

  reply_checker sb;
  int cycle_count;
  int bytes_sent;
  bit idle_en;
  bit hold_off_req;

  humidity_temp_frame_decoder_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .gain_we      (gain_we),
    .gain_wdata   (gain_wdata)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Abort on a hang
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Sample at the rising edge: a byte transaction feeds the predictor, a
  // result transaction is checked, and a gain write updates the predictor's
  // copy of the register.
  always @(posedge clk) begin
    if (!rst) begin
      if (gain_we) sb.gain = gain_wdata;
      if (byte_valid && byte_ready) sb.take_byte(byte_data);
      if (result_valid && result_ready) sb.check_reading(result);
    end
  end

  // Receiver: drive ready at the falling edge, one assignment per edge.
  // Stall in random bursts while idling is on, and hold off for a long
  // stretch on request so the pipeline fills and byte_ready drops.
  initial begin
    int stall_left;
    stall_left = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        result_ready <= 1'b0;
      end else if (stall_left > 0) begin
        result_ready <= 1'b0;
        stall_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HOLD_OFF_CYCLES - 1;
        result_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Offer one byte and hold it until the transaction completes. Enter and
  // leave at a falling edge; keep valid high between back-to-back bytes.
  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_data <= '{rx_byte: b, frame_start: start};
    do @(posedge clk); while (!byte_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Send the first 'count' bytes of a reply; t_err and h_err corrupt the CRCs.
  task automatic send_frame(input logic [15:0] st, input logic [15:0] srh,
                            input logic start, input logic [7:0] t_err,
                            input logic [7:0] h_err, input int count);
    logic [7:0] b [6];
    b[0] = st[15:8];
    b[1] = st[7:0];
    b[2] = reply_checker::crc_next(reply_checker::crc_next(hfd_pkg::CRC_INIT, b[0]),
                                   b[1]) ^ t_err;
    b[3] = srh[15:8];
    b[4] = srh[7:0];
    b[5] = reply_checker::crc_next(reply_checker::crc_next(hfd_pkg::CRC_INIT, b[3]),
                                   b[4]) ^ h_err;
    for (int i = 0; i < count; i++) send_byte(b[i], (i == 0) ? start : 1'b0);
  endtask

  // Wait for every owed reading, then let the pipeline settle.
  task automatic drain();
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write the gain while the block is idle.
  task automatic set_gain(input logic [4:0] g);
    gain_we <= 1'b1;
    gain_wdata <= g;
    @(negedge clk);
    gain_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // Mostly well-formed replies with random content; some corrupted CRCs,
  // cut-off replies and loose noise bytes to knock the framing around.
  task automatic random_phase(input int target);
    int stop_at;
    int kind;
    int n;
    bit aligned;
    logic [7:0] t_err;
    logic [7:0] h_err;
    stop_at = bytes_sent + target;
    aligned = 1'b0;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        t_err = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        h_err = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        send_frame(pick_word(), pick_word(), aligned ? 1'($urandom_range(0, 1)) : 1'b1,
                   t_err, h_err, 6);
        aligned = 1'b1;
      end else if (kind == 7) begin
        send_frame(pick_word(), pick_word(), 1'b1, 8'h00, 8'h00, $urandom_range(1, 5));
        aligned = 1'b0;
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom()), ($urandom_range(0, 3) == 0));
        aligned = 1'b0;
      end
    end
  endtask

  initial begin
    logic [4:0] gains [6];
    sb = new();
    cycle_count = 0;
    bytes_sent = 0;
    idle_en = 1'b1;
    hold_off_req = 1'b0;
    rst = 1'b1;
    byte_valid = 1'b0;
    byte_data = '0;
    gain_we = 1'b0;
    gain_wdata = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed replies at the reset gain: coldest reading with full humidity,
    // hottest reading with no frame_start, a cut-off reply dropped by an early
    // frame_start, a humidity CRC error, and both CRCs bad.
    send_frame(16'h0000, 16'hFFFF, 1'b1, 8'h00, 8'h00, 6);
    send_frame(16'hFFFF, 16'h0000, 1'b0, 8'h00, 8'h00, 6);
    send_frame(16'h1234, 16'h5678, 1'b1, 8'h01, 8'h00, 2);
    send_frame(16'h6666, 16'h9999, 1'b1, 8'h00, 8'h80, 6);
    send_frame(16'hA5A5, 16'h5A5A, 1'b1, 8'hFF, 8'hFF, 6);
    byte_valid <= 1'b0;
    drain();

    // Sweep the gain across its extremes and beyond; the last phase runs
    // with no idling on either side.
    gains[0] = 5'd1;
    gains[1] = 5'd20;
    gains[2] = 5'd0;
    gains[3] = 5'd31;
    gains[4] = 5'($urandom_range(1, 20));
    gains[5] = hfd_pkg::GAIN_RESET;
    for (int p = 0; p < 6; p++) begin
      set_gain(gains[p]);
      if (p == 1) hold_off_req = 1'b1;
      if (p == 5) idle_en = 1'b0;
      random_phase(65);
      byte_valid <= 1'b0;
      drain();
    end

    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
